FILE: hdl/mpq_pkg.sv
package mpq_pkg;

    localparam int DEPTH_DEF    = 1024;
    localparam int KEY_BITS_DEF = 16;
    localparam int TAG_BITS     = 10;

    // input item kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan_run;
        logic shift_start;
        logic shift_run;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic pass_done;
        logic out_free;
    } status_t;

endpackage

FILE: hdl/mpq_ctrl.sv
module mpq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_kind,
    output logic            s_ready,
    input  mpq_pkg::status_t status,
    output mpq_pkg::cmd_t   cmd
);

    mpq_pkg::state_t state_reg;
    mpq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mpq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            mpq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_kind == mpq_pkg::KIND_DEQ && !status.count_zero) begin
                        state_next = mpq_pkg::ST_SCAN;
                    end else begin
                        state_next = mpq_pkg::ST_RESULT;
                    end
                end
            end
            mpq_pkg::ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (status.pass_done) begin
                    cmd.shift_start = 1'b1;
                    state_next      = mpq_pkg::ST_SHIFT;
                end
            end
            mpq_pkg::ST_SHIFT: begin
                cmd.shift_run = 1'b1;
                if (status.pass_done) begin
                    state_next = mpq_pkg::ST_RESULT;
                end
            end
            mpq_pkg::ST_RESULT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = mpq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mpq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/mpq_dp.sv
module mpq_dp #(
    parameter int DEPTH    = mpq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF,
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_kind,
    input  logic [KEY_BITS-1:0]          s_key,
    input  logic [mpq_pkg::TAG_BITS-1:0] s_tag,
    input  mpq_pkg::cmd_t                cmd,
    output mpq_pkg::status_t             status,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mpq_pkg::TAG_BITS-1:0] m_out_tag,
    output logic                         m_was_empty,
    output logic                         m_was_full,
    output logic [CNT_W-1:0]             m_fill
);

    localparam int TB = mpq_pkg::TAG_BITS;
    localparam int EW = KEY_BITS + TB;

    logic [EW-1:0] mem [DEPTH];

    logic                kind_reg;
    logic [KEY_BITS-1:0] key_in_reg;
    logic [TB-1:0]       tag_in_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    idx_next;
    logic                rd_vld_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic [EW-1:0]       rd_data_reg;

    logic                first_reg;
    logic [KEY_BITS-1:0] best_key_reg;
    logic [TB-1:0]       best_tag_reg;
    logic [ADDR_W-1:0]   best_pos_reg;

    logic                m_valid_reg;
    logic [TB-1:0]       out_tag_reg;
    logic                out_empty_reg;
    logic                out_full_reg;
    logic [CNT_W-1:0]    out_fill_reg;

    logic                issue;
    logic                run;
    logic                is_full;
    logic                is_empty;
    logic [KEY_BITS-1:0] rd_key;
    logic [TB-1:0]       rd_tag;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [EW-1:0]       mem_wdata;

    assign run      = cmd.scan_run | cmd.shift_run;
    assign issue    = idx_reg < count_reg;
    assign is_full  = count_reg == CNT_W'(DEPTH);
    assign is_empty = count_reg == '0;
    assign rd_key   = rd_data_reg[EW-1:TB];
    assign rd_tag   = rd_data_reg[TB-1:0];

    assign status.count_zero = is_empty;
    assign status.pass_done  = !issue && !rd_vld_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        idx_next = idx_reg;
        if (cmd.accept) begin
            idx_next = '0;
        end else if (cmd.shift_start) begin
            idx_next = CNT_W'(best_pos_reg) + CNT_W'(1);
        end else if (run && issue) begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    // one write port: enqueue append or shift-down move
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = rd_addr_reg - ADDR_W'(1);
        mem_wdata = rd_data_reg;
        if (cmd.shift_run && rd_vld_reg) begin
            mem_we = 1'b1;
        end else if (cmd.commit && kind_reg == mpq_pkg::KIND_ENQ && !is_full) begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[ADDR_W-1:0];
            mem_wdata = {key_in_reg, tag_in_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (run && issue) begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
            rd_addr_reg <= idx_reg[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg   <= s_kind;
            key_in_reg <= s_key;
            tag_in_reg <= s_tag;
        end
        idx_reg <= idx_next;
        if (cmd.scan_run && rd_vld_reg && (first_reg || rd_key > best_key_reg)) begin
            best_key_reg <= rd_key;
            best_tag_reg <= rd_tag;
            best_pos_reg <= rd_addr_reg;
        end
        if (cmd.accept) begin
            first_reg <= 1'b1;
        end else if (cmd.scan_run && rd_vld_reg) begin
            first_reg <= 1'b0;
        end
        if (cmd.commit) begin
            if (kind_reg == mpq_pkg::KIND_ENQ) begin
                out_tag_reg   <= '0;
                out_empty_reg <= 1'b0;
                out_full_reg  <= is_full;
                out_fill_reg  <= is_full ? count_reg : count_reg + CNT_W'(1);
            end else begin
                out_tag_reg   <= is_empty ? '0 : best_tag_reg;
                out_empty_reg <= is_empty;
                out_full_reg  <= 1'b0;
                out_fill_reg  <= is_empty ? count_reg : count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= run && issue;
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
                if (kind_reg == mpq_pkg::KIND_ENQ && !is_full) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else if (kind_reg == mpq_pkg::KIND_DEQ && !is_empty) begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_tag   = out_tag_reg;
    assign m_was_empty = out_empty_reg;
    assign m_was_full  = out_full_reg;
    assign m_fill      = out_fill_reg;

endmodule

FILE: hdl/max_priority_queue_linear_scan.sv
// Max priority queue of (key, tag) pairs held in one on-chip memory, in arrival order.
// Input channel (s_): s_kind selects enqueue or dequeue; s_key and s_tag matter for an
// enqueue only. One transfer in gives exactly one transfer out on the m_ channel.
// Result channel (m_): m_out_tag is the tag of the removed highest-key entry (earliest
// on a tie), m_was_empty / m_was_full flag a dequeue on an empty queue or a dropped
// enqueue, m_fill is the entry count after the item.
// Sequence: an enqueue, an empty dequeue or a full enqueue goes from idle straight to
// posting its result. A dequeue first scans all held entries for the max, then shifts
// every entry after the max down one place, then posts the result. The single memory
// read port, with one entry read per cycle in both passes, sets how long a dequeue takes.
// Handshake: one item is worked at a time; s_ready is high only while the block is
// idle, which it re-enters as the result is registered.
// Reset clears the entry count and the output valid; memory contents are not cleared
// and need not be, since no entry at or above the count is ever read.
// If the receiver stalls, the result holds in the output register and the next item
// is still taken; its result waits until the output register frees up.
module max_priority_queue_linear_scan #(
    parameter int DEPTH    = mpq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF,
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [KEY_BITS-1:0]          s_key,
    input  logic [mpq_pkg::TAG_BITS-1:0] s_tag,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mpq_pkg::TAG_BITS-1:0] m_out_tag,
    output logic                         m_was_empty,
    output logic                         m_was_full,
    output logic [CNT_W-1:0]             m_fill
);

    mpq_pkg::cmd_t    cmd;
    mpq_pkg::status_t status;

    // sequencing: idle -> scan for max -> shift later entries down -> post result; other items skip to post
    mpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // entry memory, scan and shift pointers, count and output register
    mpq_dp #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_kind      (s_kind),
        .s_key       (s_key),
        .s_tag       (s_tag),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_tag   (m_out_tag),
        .m_was_empty (m_was_empty),
        .m_was_full  (m_was_full),
        .m_fill      (m_fill)
    );

endmodule

FILE: test/max_priority_queue_linear_scan_tb.sv
`timescale 1ns / 1ps

module max_priority_queue_linear_scan_tb;

    localparam int DEPTH        = mpq_pkg::DEPTH_DEF;
    localparam int KEY_BITS     = mpq_pkg::KEY_BITS_DEF;
    localparam int TAG_BITS     = mpq_pkg::TAG_BITS;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    // worst dequeue: full scan plus full shift, then post the result
    localparam int MAX_LATENCY  = 2 * DEPTH + 5;
    localparam int MAX_IDLE     = 19;
    localparam int RANDOM_ITEMS = 270;
    localparam int N_ROWS       = 21;
    // bound on items ever sent (directed + random), times the slowest item
    localparam int MAX_ITEMS    = 400;
    localparam int LIMIT_CYCLES = MAX_ITEMS * (MAX_LATENCY + 2 * MAX_IDLE + 2) * 3;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [TAG_BITS-1:0] out_tag;
        logic                was_empty;
        logic                was_full;
        logic [CNT_W-1:0]    fill;
    } outcome_t;

    typedef struct {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    // one directed item; the w_ fields hold a typed-in outcome when typed is set
    typedef struct {
        logic                kind;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        bit                  typed;
        logic [TAG_BITS-1:0] w_tag;
        logic                w_empty;
        logic                w_full;
        logic [CNT_W-1:0]    w_fill;
    } row_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_kind  = mpq_pkg::KIND_ENQ;
    logic [KEY_BITS-1:0] s_key   = '0;
    logic [TAG_BITS-1:0] s_tag   = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [TAG_BITS-1:0] m_out_tag;
    logic                m_was_empty;
    logic                m_was_full;
    logic [CNT_W-1:0]    m_fill;

    // software copy of the queue contents, in arrival order
    entry_t   held_entries[$];
    // outcomes owed by the block, oldest first
    outcome_t due_results[$];

    int fail_count   = 0;
    int result_count = 0;
    int cycle_count  = 0;
    int stall_left   = 0;
    // set for stretches where neither side idles
    bit no_idle      = 1'b0;

    max_priority_queue_linear_scan dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_key       (s_key),
        .s_tag       (s_tag),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_tag   (m_out_tag),
        .m_was_empty (m_was_empty),
        .m_was_full  (m_was_full),
        .m_fill      (m_fill)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Apply one item to the queue copy and return the outcome it gives.
    // Dequeue: scan for the largest key, strict compare so the earliest entry wins a tie.
    function automatic outcome_t apply_queue_op(input logic kind,
                                                input logic [KEY_BITS-1:0] key,
                                                input logic [TAG_BITS-1:0] tag);
        outcome_t o;
        entry_t   e;
        int       best;
        o = '{default: '0};
        if (kind == mpq_pkg::KIND_ENQ) begin
            if (held_entries.size() >= DEPTH) begin
                o.was_full = 1'b1;
            end else begin
                e.key = key;
                e.tag = tag;
                held_entries.push_back(e);
            end
        end else if (held_entries.size() == 0) begin
            o.was_empty = 1'b1;
        end else begin
            best = 0;
            for (int i = 1; i < held_entries.size(); i++) begin
                if (held_entries[i].key > held_entries[best].key)
                    best = i;
            end
            o.out_tag = held_entries[best].tag;
            held_entries.delete(best);
        end
        o.fill = CNT_W'(held_entries.size());
        return o;
    endfunction

    // Mix narrow keys (ties), the two extremes and full-range keys.
    function automatic logic [KEY_BITS-1:0] random_key();
        case ($urandom_range(5, 0))
            0, 1:    return KEY_BITS'($urandom_range(7, 0));
            2:       return '0;
            3:       return '1;
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    // Idle for a random gap, then hold the item on the bus until it transfers.
    // Owe the typed-in outcome when given, else the one the queue copy works out.
    task automatic transfer_item(input logic kind, input logic [KEY_BITS-1:0] key,
                                 input logic [TAG_BITS-1:0] tag, input bit typed,
                                 input outcome_t typed_out);
        int       gap;
        outcome_t o;
        gap = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_key   <= key;
        s_tag   <= tag;
        do @(posedge aclk); while (!s_ready);
        o = apply_queue_op(kind, key, tag);
        due_results.push_back(typed ? typed_out : o);
    endtask

    task automatic random_item(input logic kind);
        transfer_item(kind, random_key(), TAG_BITS'($urandom_range(1023, 0)), 1'b0,
                      '{default: '0});
    endtask

    // Drop valid and hold off until every owed outcome has come back.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    // Result side: check each transfer against the oldest owed outcome, then draw
    // the stall before the next transfer. The countdown runs whether or not a result
    // is pending, so stalls land on every phase of the scan and shift.
    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("result %0d: transfer with no outcome owed", result_count);
                end else begin
                    want = due_results.pop_front();
                    if (m_out_tag !== want.out_tag || m_was_empty !== want.was_empty ||
                        m_was_full !== want.was_full || m_fill !== want.fill) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("result %0d got  tag %0d empty %0b full %0b fill %0d",
                                     result_count, m_out_tag, m_was_empty, m_was_full,
                                     m_fill);
                            $display("result %0d want tag %0d empty %0b full %0b fill %0d",
                                     result_count, want.out_tag, want.was_empty,
                                     want.was_full, want.fill);
                        end
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Hang guard.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        row_t     rows[N_ROWS];
        outcome_t typed_out;
        int       sent;
        int       n_enq;
        int       n_deq;

        // Typed rows: empty after reset, a tie on the all-ones key (earliest tag first),
        // key zero leaving last with tag zero but not empty, then empty again.
        // Dequeue rows with nonzero key/tag check that those fields are ignored.
        rows = '{
            '{mpq_pkg::KIND_DEQ, 16'h0000, 10'h000, 1'b1, 10'h000, 1'b1, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_ENQ, 16'h0000, 10'h000, 1'b1, 10'h000, 1'b0, 1'b0, CNT_W'(1)},
            '{mpq_pkg::KIND_ENQ, 16'hFFFF, 10'h3FF, 1'b1, 10'h000, 1'b0, 1'b0, CNT_W'(2)},
            '{mpq_pkg::KIND_ENQ, 16'h1234, 10'h155, 1'b1, 10'h000, 1'b0, 1'b0, CNT_W'(3)},
            '{mpq_pkg::KIND_ENQ, 16'hFFFF, 10'h2AA, 1'b1, 10'h000, 1'b0, 1'b0, CNT_W'(4)},
            '{mpq_pkg::KIND_DEQ, 16'hFFFF, 10'h3FF, 1'b1, 10'h3FF, 1'b0, 1'b0, CNT_W'(3)},
            '{mpq_pkg::KIND_DEQ, 16'h0000, 10'h000, 1'b1, 10'h2AA, 1'b0, 1'b0, CNT_W'(2)},
            '{mpq_pkg::KIND_DEQ, 16'h0000, 10'h000, 1'b1, 10'h155, 1'b0, 1'b0, CNT_W'(1)},
            '{mpq_pkg::KIND_DEQ, 16'h0000, 10'h000, 1'b1, 10'h000, 1'b0, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_DEQ, 16'h0000, 10'h000, 1'b1, 10'h000, 1'b1, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_ENQ, 16'h8000, 10'h001, 1'b0, 10'h000, 1'b0, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_ENQ, 16'h7FFF, 10'h200, 1'b0, 10'h000, 1'b0, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_ENQ, 16'h8000, 10'h100, 1'b0, 10'h000, 1'b0, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_ENQ, 16'h0001, 10'h3FE, 1'b0, 10'h000, 1'b0, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_DEQ, 16'hABCD, 10'h123, 1'b0, 10'h000, 1'b0, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_ENQ, 16'hFFFE, 10'h0AA, 1'b0, 10'h000, 1'b0, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_DEQ, 16'h0000, 10'h000, 1'b0, 10'h000, 1'b0, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_DEQ, 16'h0000, 10'h000, 1'b0, 10'h000, 1'b0, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_DEQ, 16'h0000, 10'h000, 1'b0, 10'h000, 1'b0, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_DEQ, 16'h0000, 10'h000, 1'b0, 10'h000, 1'b0, 1'b0, CNT_W'(0)},
            '{mpq_pkg::KIND_DEQ, 16'h0000, 10'h000, 1'b0, 10'h000, 1'b0, 1'b0, CNT_W'(0)}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table.
        foreach (rows[i]) begin
            typed_out = '{rows[i].w_tag, rows[i].w_empty, rows[i].w_full, rows[i].w_fill};
            transfer_item(rows[i].kind, rows[i].key, rows[i].tag, rows[i].typed, typed_out);
        end
        hold_until_drained();

        // Random part: mostly fill-then-drain runs with random content, the rest
        // noise of random kinds. Some runs go without idling; some end with a drain.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(3, 0) == 0);
            if ($urandom_range(3, 0) != 0) begin
                n_enq = $urandom_range(12, 1);
                n_deq = $urandom_range(n_enq + 2, 1);
                repeat (n_enq) random_item(mpq_pkg::KIND_ENQ);
                repeat (n_deq) random_item(mpq_pkg::KIND_DEQ);
                sent += n_enq + n_deq;
            end else begin
                repeat (8) random_item($urandom_range(1, 0) ? mpq_pkg::KIND_DEQ
                                                            : mpq_pkg::KIND_ENQ);
                sent += 8;
            end
            if ($urandom_range(7, 0) == 0)
                hold_until_drained();
        end

        // Wait out every owed outcome, then a full latency for any stray transfer.
        no_idle = 1'b0;
        hold_until_drained();
        repeat (MAX_LATENCY + 16) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
